// ----- hw/rtl/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Shared types and constants for the deframer: parse phases, result kinds,
// header bytes and the result record passed from the parser to the top level.
// ----------------------------------------------------------------------------
package tfd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_FRAME_A = 3'd1,
        PH_FRAME_B = 3'd2,
        PH_QUAD    = 3'd3,
        PH_ACK     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_FRAME_A   = 3'd0,
        KIND_FRAME_B   = 3'd1,
        KIND_QUAD      = 3'd2,
        KIND_XYZ_OK    = 3'd3,
        KIND_XYZ_FAIL  = 3'd4,
        KIND_UVW_OK    = 3'd5,
        KIND_UVW_RESEND = 3'd6
    } t_kind;

    // Header characters.
    localparam logic [7:0] HDR_A = 8'h61;  // 'a'
    localparam logic [7:0] HDR_B = 8'h62;  // 'b'
    localparam logic [7:0] HDR_C = 8'h63;  // 'c'
    localparam logic [7:0] HDR_X = 8'h78;  // 'x'
    localparam logic [7:0] HDR_Y = 8'h79;  // 'y'
    localparam logic [7:0] HDR_Z = 8'h7A;  // 'z'
    localparam logic [7:0] HDR_U = 8'h75;  // 'u'
    localparam logic [7:0] HDR_V = 8'h76;  // 'v'
    localparam logic [7:0] HDR_W = 8'h77;  // 'w'

    // Acknowledge byte that signals success: '1'.
    localparam logic [7:0] ACK_OK_BYTE = 8'h31;

    // Pending acknowledge kinds.
    localparam logic ACK_KIND_XYZ = 1'b0;
    localparam logic ACK_KIND_UVW = 1'b1;

    // Drone types held in the configuration register.
    localparam logic DRONE_FIXED_WING = 1'b0;
    localparam logic DRONE_QUAD       = 1'b1;

    // Configuration register byte address.
    localparam logic [2:0] ADDR_DRONE_TYPE = 3'd0;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last_of_frame;
        logic       plan_ok;
    } t_result;

endpackage

// ----- hw/rtl/tfd_parser.sv -----
// ----------------------------------------------------------------------------
// Deframer parser
// Holds the header window and frame state, and works out the result of one
// byte combinationally. State advances when the top level steps it.
// ----------------------------------------------------------------------------
module tfd_parser #(
    parameter int FRAME_A_BYTES    = 28,
    parameter int FRAME_B_BYTES    = 34,
    parameter int QUAD_FRAME_BYTES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_drone_type,
    output logic             o_has_result,
    output tfd_pkg::t_result o_result
);
    import tfd_pkg::*;

    localparam logic [8:0] LEN_A    = 9'(FRAME_A_BYTES);
    localparam logic [8:0] LEN_B    = 9'(FRAME_B_BYTES);
    localparam logic [8:0] LEN_QUAD = 9'(QUAD_FRAME_BYTES);

    t_phase      r_phase, n_phase;
    logic [15:0] r_recent, n_recent;
    logic [1:0]  r_count, n_count;
    logic [7:0]  r_pos, n_pos;
    logic        r_ack_kind, n_ack_kind;
    logic        r_plan, n_plan;

    logic [8:0] pos_inc;
    logic       last_a, last_b, last_q;
    logic       win_full, hit_abc, hit_xyz, hit_uvw;

    assign pos_inc = {1'b0, r_pos} + 9'd1;
    assign last_a  = (pos_inc >= LEN_A);
    assign last_b  = (pos_inc >= LEN_B);
    assign last_q  = (pos_inc >= LEN_QUAD);

    assign win_full = (r_count == 2'd2);
    assign hit_abc  = win_full && (r_recent[15:8] == HDR_A) && (r_recent[7:0] == HDR_B)
                      && (i_byte == HDR_C);
    assign hit_xyz  = win_full && (r_recent[15:8] == HDR_X) && (r_recent[7:0] == HDR_Y)
                      && (i_byte == HDR_Z);
    assign hit_uvw  = win_full && (r_recent[15:8] == HDR_U) && (r_recent[7:0] == HDR_V)
                      && (i_byte == HDR_W);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_FRAME_A: if (last_a) n_phase = PH_FRAME_B;
            PH_FRAME_B: if (last_b) n_phase = PH_HUNT;
            PH_QUAD:    if (last_q) n_phase = PH_HUNT;
            PH_ACK:     n_phase = PH_HUNT;
            default: begin
                if (hit_abc) begin
                    n_phase = (i_drone_type == DRONE_QUAD) ? PH_QUAD : PH_FRAME_A;
                end else if ((hit_xyz || hit_uvw) && (i_drone_type == DRONE_FIXED_WING)) begin
                    n_phase = PH_ACK;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Result and data state.
    always_comb begin
        n_recent            = r_recent;
        n_count             = r_count;
        n_pos               = r_pos;
        n_ack_kind          = r_ack_kind;
        n_plan              = r_plan;
        o_has_result        = 1'b1;
        o_result.kind       = KIND_FRAME_A;
        o_result.payload_byte = i_byte;
        o_result.byte_index = r_pos;
        o_result.last_of_frame = 1'b0;
        unique case (r_phase)
            PH_FRAME_A: begin
                o_result.kind          = KIND_FRAME_A;
                o_result.last_of_frame = last_a;
                n_pos                  = last_a ? 8'd0 : pos_inc[7:0];
            end
            PH_FRAME_B: begin
                o_result.kind          = KIND_FRAME_B;
                o_result.last_of_frame = last_b;
                n_pos                  = last_b ? 8'd0 : pos_inc[7:0];
            end
            PH_QUAD: begin
                o_result.kind          = KIND_QUAD;
                o_result.last_of_frame = last_q;
                n_pos                  = last_q ? 8'd0 : pos_inc[7:0];
            end
            PH_ACK: begin
                o_result.byte_index    = 8'd0;
                o_result.last_of_frame = 1'b1;
                if (r_ack_kind == ACK_KIND_UVW) begin
                    if (i_byte == ACK_OK_BYTE) begin
                        n_plan        = 1'b1;
                        o_result.kind = KIND_UVW_OK;
                    end else begin
                        n_plan        = 1'b0;
                        o_result.kind = KIND_UVW_RESEND;
                    end
                end else begin
                    if (i_byte == ACK_OK_BYTE) begin
                        o_result.kind = KIND_XYZ_OK;
                    end else begin
                        // A failed xyz ack restarts the protocol.
                        n_plan        = 1'b0;
                        o_result.kind = KIND_XYZ_FAIL;
                    end
                end
            end
            default: begin
                o_has_result = 1'b0;
                if (hit_abc) begin
                    n_recent = 16'd0;
                    n_count  = 2'd0;
                    n_pos    = 8'd0;
                end else if (hit_xyz || hit_uvw) begin
                    n_recent = 16'd0;
                    n_count  = 2'd0;
                    if (i_drone_type == DRONE_FIXED_WING) begin
                        n_ack_kind = hit_uvw ? ACK_KIND_UVW : ACK_KIND_XYZ;
                    end
                end else begin
                    n_recent = {r_recent[7:0], i_byte};
                    if (r_count != 2'd2) n_count = r_count + 2'd1;
                end
            end
        endcase
        o_result.plan_ok = n_plan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_recent   <= 16'd0;
            r_count    <= 2'd0;
            r_pos      <= 8'd0;
            r_ack_kind <= ACK_KIND_XYZ;
            r_plan     <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_recent   <= n_recent;
            r_count    <= n_count;
            r_pos      <= n_pos;
            r_ack_kind <= n_ack_kind;
            r_plan     <= n_plan;
        end
    end

endmodule

// ----- hw/rtl/telemetry_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Telemetry frame deframer
// Received serial bytes enter on the s_axis channel, one byte per transfer.
// A three-byte window hunts for the headers abc, xyz and uvw. In fixed-wing
// mode abc opens a frame A followed by a frame B, and xyz or uvw is followed
// by one acknowledge byte; in quad mode abc opens one quad frame and the
// other headers are dropped. Header bytes never appear at the output.
// Every payload or acknowledge byte yields one m_axis transfer: tuser is the
// kind, tlast marks the final byte of a frame or an ack, tdata carries the
// byte, its index within the frame and the plan-ok flag.
// A result passes through the input register, then the parser logic into the
// result register, before it is valid. One byte is taken every cycle as long
// as the result register is free or drained; bytes that give no result never
// wait on the output.
// Reset empties both registers, clears the window, frame state and plan
// flag, and sets the drone type to fixed wing. When the receiver stalls
// with a result waiting, s_axis_tready drops only if the held byte would
// produce another result. The drone type is written over the APB port at
// byte address 0 and sampled when a header completes.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_unit #(
    parameter int FRAME_A_BYTES    = 28,
    parameter int FRAME_B_BYTES    = 34,
    parameter int QUAD_FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                        // [16] plan_ok, [23:17] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,   // last_of_frame
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfd_pkg::*;

    logic    r_drone_type;
    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;

    logic    step;
    logic    has_result;
    t_result result;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DRONE_TYPE) ? {31'd0, r_drone_type} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drone_type <= DRONE_FIXED_WING;
        end else if (psel && penable && pwrite && (paddr == ADDR_DRONE_TYPE)) begin
            r_drone_type <= pwdata[0];
        end
    end

    // The held byte moves on unless it makes a result and the output is full.
    assign step = r_in_valid && (!has_result || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    tfd_parser #(
        .FRAME_A_BYTES    (FRAME_A_BYTES),
        .FRAME_B_BYTES    (FRAME_B_BYTES),
        .QUAD_FRAME_BYTES (QUAD_FRAME_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_drone_type (r_drone_type),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_result) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last_of_frame;
    assign m_axis_tdata  = {7'd0, r_out.plan_ok, r_out.byte_index, r_out.payload_byte};

endmodule
